[src/upd_pkg.sv]
// shared types, character codes and hex helpers of the urlencoded pair decoder
// used by upd_front, upd_queue, upd_back and urlencoded_pair_decoder_core
package upd_pkg;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // most results one input word can cause
    localparam int MAX_ITEMS = 3;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

    // separator modes
    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_COOKIE = 1'b1;

    // escape hold counts
    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PERCENT = 2'd1;
    localparam logic [1:0] HELD_DIGIT   = 2'd2;
    localparam logic [1:0] HELD_BAD     = 2'd3;

    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_PAIR_END = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    // results of one input word, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_item [MAX_ITEMS-1:0] item;
    } t_job;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F);
    endfunction

    // nibble of a hex digit, zero for anything else
    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] v;
        v = '0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = c - CH_DIGIT_0;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            v = c - CH_UPPER_A + HEX_ALPHA_OFS;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            v = c - CH_LOWER_A + HEX_ALPHA_OFS;
        end
        return v[3:0];
    endfunction

endpackage

[src/upd_front.sv]
// front end: takes raw words, tracks token and escape state, builds one job per word
// depends on upd_pkg
module upd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_accept,
    input  logic [7:0]     i_raw_byte,
    output upd_pkg::t_job  o_job
);

    logic       r_mode;
    logic       r_token_open, n_token_open;
    logic       r_in_value, n_in_value;
    logic       r_at_start, n_at_start;
    logic [1:0] r_held_count, n_held_count;
    logic [7:0] r_held_digit, n_held_digit;

    logic          cookie;
    logic          delim;
    logic [7:0]    c_byte;
    logic          c_hex;
    logic [1:0]    held;
    upd_pkg::t_kind part_kind;
    logic          emit_pct;
    logic          emit_dig;
    logic          emit_main;
    upd_pkg::t_kind main_kind;
    logic [7:0]    main_byte;
    logic [1:0]    slot;

    // classification of the incoming word
    assign cookie    = (r_mode == upd_pkg::MODE_COOKIE);
    assign delim     = (i_raw_byte == upd_pkg::CH_NUL) ||
                       (!cookie && i_raw_byte == upd_pkg::CH_AMP) ||
                       (cookie && i_raw_byte == upd_pkg::CH_SEMI);
    assign c_byte    = (!cookie && i_raw_byte == upd_pkg::CH_PLUS) ?
                       upd_pkg::CH_SPACE : i_raw_byte;
    assign c_hex     = upd_pkg::is_hex(c_byte);
    assign held      = (r_held_count == upd_pkg::HELD_BAD) ? upd_pkg::HELD_NONE : r_held_count;
    assign part_kind = r_in_value ? upd_pkg::KIND_VALUE : upd_pkg::KIND_KEY;

    // next state and which results this word causes
    always_comb begin
        n_token_open = r_token_open;
        n_in_value   = r_in_value;
        n_at_start   = r_at_start;
        n_held_count = held;
        n_held_digit = r_held_digit;
        emit_pct     = 1'b0;
        emit_dig     = 1'b0;
        emit_main    = 1'b0;
        main_kind    = part_kind;
        main_byte    = c_byte;
        if (delim) begin
            emit_pct     = (held != upd_pkg::HELD_NONE);
            emit_dig     = (held == upd_pkg::HELD_DIGIT);
            emit_main    = r_token_open;
            main_kind    = upd_pkg::KIND_PAIR_END;
            main_byte    = '0;
            n_token_open = 1'b0;
            n_in_value   = 1'b0;
            n_at_start   = 1'b1;
            n_held_count = upd_pkg::HELD_NONE;
            n_held_digit = '0;
        end else begin
            n_token_open = 1'b1;
            if (!(cookie && r_at_start && i_raw_byte == upd_pkg::CH_SPACE)) begin
                n_at_start = 1'b0;
                if (i_raw_byte == upd_pkg::CH_EQUAL && !r_in_value) begin
                    emit_pct     = (held != upd_pkg::HELD_NONE);
                    emit_dig     = (held == upd_pkg::HELD_DIGIT);
                    n_held_count = upd_pkg::HELD_NONE;
                    n_in_value   = 1'b1;
                end else if (held == upd_pkg::HELD_PERCENT && c_hex) begin
                    n_held_digit = c_byte;
                    n_held_count = upd_pkg::HELD_DIGIT;
                end else if (held == upd_pkg::HELD_DIGIT && c_hex) begin
                    emit_main    = 1'b1;
                    main_byte    = {upd_pkg::hex_nibble(r_held_digit),
                                    upd_pkg::hex_nibble(c_byte)};
                    n_held_count = upd_pkg::HELD_NONE;
                end else begin
                    // bad escape is flushed, then the word is taken fresh
                    emit_pct = (held != upd_pkg::HELD_NONE);
                    emit_dig = (held == upd_pkg::HELD_DIGIT);
                    if (c_byte == upd_pkg::CH_PERCENT) begin
                        n_held_count = upd_pkg::HELD_PERCENT;
                    end else begin
                        n_held_count = upd_pkg::HELD_NONE;
                        emit_main    = 1'b1;
                    end
                end
            end
        end
    end

    // pack the results into consecutive slots
    always_comb begin
        o_job = '0;
        slot  = '0;
        if (emit_pct) begin
            o_job.item[slot].kind = part_kind;
            o_job.item[slot].data = upd_pkg::CH_PERCENT;
            slot = slot + 2'd1;
        end
        if (emit_dig) begin
            o_job.item[slot].kind = part_kind;
            o_job.item[slot].data = r_held_digit;
            slot = slot + 2'd1;
        end
        if (emit_main) begin
            o_job.item[slot].kind = main_kind;
            o_job.item[slot].data = main_byte;
            slot = slot + 2'd1;
        end
        o_job.count = slot;
    end

    // mode register and token state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= upd_pkg::MODE_QUERY;
            r_token_open <= 1'b0;
            r_in_value   <= 1'b0;
            r_at_start   <= 1'b1;
            r_held_count <= upd_pkg::HELD_NONE;
            r_held_digit <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_token_open <= n_token_open;
                r_in_value   <= n_in_value;
                r_at_start   <= n_at_start;
                r_held_count <= n_held_count;
                r_held_digit <= n_held_digit;
            end
        end
    end

endmodule

[src/upd_queue.sv]
// job queue between front and back, register based, head read combinationally
// depends on upd_pkg
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_job i_push_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output upd_pkg::t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

[src/upd_back.sv]
// back end: walks the slots of each job and feeds the result output register
// depends on upd_pkg
module upd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  upd_pkg::t_job  i_q_head,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output upd_pkg::t_kind o_kind,
    output logic [7:0]     o_data,
    output logic           o_last
);

    logic           r_busy, n_busy;
    upd_pkg::t_job  r_job, n_job;
    logic [1:0]     r_idx, n_idx;
    logic           r_m_valid;
    upd_pkg::t_kind r_m_kind;
    logic [7:0]     r_m_data;
    logic           r_m_last;

    logic  load_out;
    logic  take;
    logic  cur_last;
    logic  refill;

    assign load_out = !r_m_valid || i_ready;
    assign take     = load_out && r_busy;
    assign cur_last = (r_idx == r_job.count - 2'd1);
    assign refill   = !r_busy || (take && cur_last);
    assign o_q_pop  = refill && i_q_valid;

    // slot walk and job refill from the queue
    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_idx  = r_idx;
        if (refill) begin
            n_busy = i_q_valid;
            n_job  = i_q_head;
            n_idx  = '0;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (load_out) begin
                r_m_valid <= r_busy;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (take) begin
            r_m_kind <= r_job.item[r_idx].kind;
            r_m_data <= r_job.item[r_idx].data;
            r_m_last <= cur_last;
        end
    end

    assign o_valid = r_m_valid;
    assign o_kind  = r_m_kind;
    assign o_data  = r_m_data;
    assign o_last  = r_m_last;

endmodule

[src/urlencoded_pair_decoder_core.sv]
// top level of the urlencoded pair decoder: front end, job queue and back end
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
// channel   direction  signals                       contents
// s_axis    in         tvalid tready tdata[7:0]      raw_byte
// m_axis    out        tvalid tready tdata[7:0]      out_byte
//                      tuser[1:0] tlast              item_kind, run_last
// cfg       in         i_cfg_wr_en i_cfg_wr_data     separator_mode
//
// one input word is taken per cycle while the job queue has room; each word
// yields zero to three results, sent one per cycle while m_axis_tready is high
// from the output register; each result passes the queue, job and output registers
// the queue depth sets how far input runs ahead of a stalled output
// synchronous active-low reset clears control state, not data; no clearing pass is needed
module urlencoded_pair_decoder_core #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] raw_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] item_kind
    output logic       m_axis_tlast    // run_last
);

    upd_pkg::t_job  front_job;
    upd_pkg::t_job  q_head;
    upd_pkg::t_kind out_kind;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           in_accept;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // classify words and keep token state
    upd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_raw_byte    (s_axis_tdata),
        .o_job         (front_job)
    );

    // jobs with no result are not queued
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_accept && (front_job.count != 2'd0)),
        .i_push_job (front_job),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    // serialize results
    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (out_kind),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

`ifndef NO_ASSERTIONS
    // a pair end closes the results of its word and carries a zero byte
    a_pair_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == upd_pkg::KIND_PAIR_END) |->
        (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("pair end without last or with nonzero byte");

    // no empty job ever reaches the queue head
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_head.count != 2'd0))
        else $error("empty job in queue");

    // output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
